// ----- hdl/sqtr_pkg.sv -----
package sqtr_pkg;

  // Grid geometry. The store holds MAX_SIDE rows of MAX_SIDE cells.
  localparam int MAX_SIDE = 64;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int ROW_W    = $clog2(MAX_SIDE);

  // Field widths fixed by the interface.
  localparam int CELL_W   = 13;
  localparam int SIDE_W   = 7;
  localparam int RAD_W    = 5;
  localparam int OP_W     = 2;

  // Width for bounds arithmetic on rows, columns and side.
  localparam int CMP_W    = ((ROW_W + 1 > SIDE_W) ? ROW_W + 1 : SIDE_W) + 1;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RESET = SIDE_W'(64);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_FILL   = 2'd0;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Status codes.
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  // Port requests from the sequencer to the grid and scratch memories.
  typedef struct packed {
    logic              grid_we;
    logic [ADDR_W-1:0] grid_waddr;
    logic [CELL_W-1:0] grid_wdata;
    logic [ADDR_W-1:0] grid_raddr;
    logic              scr_we;
    logic [ADDR_W-1:0] scr_waddr;
    logic [CELL_W-1:0] scr_wdata;
    logic [ADDR_W-1:0] scr_raddr;
  } mem_req_t;

  // Linear store address of a 0-based row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(MAX_SIDE);
    return base + ADDR_W'(col);
  endfunction

endpackage

// ----- hdl/sqtr_ram.sv -----
module sqtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sqtr_ctrl.sv -----
module sqtr_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [sqtr_pkg::OP_W-1:0]    opcode,
  input  logic [sqtr_pkg::SIDE_W-1:0]  center_row,
  input  logic [sqtr_pkg::SIDE_W-1:0]  center_col,
  input  logic [sqtr_pkg::RAD_W-1:0]   radius,
  input  logic                         direction,
  input  logic [sqtr_pkg::CMP_W-1:0]   side,
  input  logic [sqtr_pkg::CELL_W-1:0]  grid_q,
  input  logic [sqtr_pkg::CELL_W-1:0]  scr_q,
  output sqtr_pkg::mem_req_t           mem_req,
  output logic                         done,
  output logic [sqtr_pkg::CELL_W-1:0]  cell_value,
  output logic                         status
);
  import sqtr_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_ROT1  = 3'd3;
  localparam logic [2:0] ST_GAP   = 3'd4;
  localparam logic [2:0] ST_ROT2  = 3'd5;
  localparam logic [2:0] ST_FLUSH = 3'd6;
  localparam logic [2:0] ST_READ  = 3'd7;

  logic [2:0]        state;
  logic [ROW_W-1:0]  i;
  logic [ROW_W-1:0]  j;
  logic [ROW_W-1:0]  lim;
  logic [ROW_W-1:0]  tr;
  logic [ROW_W-1:0]  tc;
  logic              dir;
  logic [CELL_W-1:0] fill_val;
  logic [ADDR_W-1:0] clr_addr;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;

  logic [CMP_W-1:0]  row_x;
  logic [CMP_W-1:0]  col_x;
  logic [CMP_W-1:0]  rad_x;
  logic [CMP_W-1:0]  row_m1;
  logic [CMP_W-1:0]  col_m1;
  logic [CMP_W-1:0]  top_row;
  logic [CMP_W-1:0]  top_col;
  logic [CMP_W-1:0]  side_m1;
  logic              rot_ok;
  logic              rd_ok;
  logic              last_cell;
  logic              last_row;
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dst_addr;

  // Bounds checks on the request at the input ports.
  assign row_x   = CMP_W'(center_row);
  assign col_x   = CMP_W'(center_col);
  assign rad_x   = CMP_W'(radius);
  assign row_m1  = row_x - CMP_W'(1);
  assign col_m1  = col_x - CMP_W'(1);
  assign top_row = row_m1 - rad_x;
  assign top_col = col_m1 - rad_x;
  assign side_m1 = side - CMP_W'(1);
  assign rot_ok  = (row_x >= rad_x + CMP_W'(1)) && (row_x + rad_x <= side) &&
                   (col_x >= rad_x + CMP_W'(1)) && (col_x + rad_x <= side);
  assign rd_ok   = (row_x != '0) && (row_x <= side) &&
                   (col_x != '0) && (col_x <= side);

  // Walk position within the square or the grid.
  assign last_row  = (j == lim);
  assign last_cell = (i == lim) && last_row;

  // Source cell at (tr+i, tc+j); its image after a quarter turn.
  always_comb begin
    src_addr = cell_addr(tr + i, tc + j);
    if (dir) begin
      dst_addr = cell_addr(tr + (lim - j), tc + i);
    end else begin
      dst_addr = cell_addr(tr + j, tc + (lim - i));
    end
  end

  assign busy = (state != ST_IDLE);

  // Memory port requests for the current state.
  always_comb begin
    mem_req            = '0;
    mem_req.scr_wdata  = grid_q;
    mem_req.scr_waddr  = pend_addr;
    mem_req.scr_raddr  = src_addr;
    mem_req.grid_raddr = src_addr;
    unique case (state)
      ST_CLEAR: begin
        mem_req.grid_we    = 1'b1;
        mem_req.grid_waddr = clr_addr;
      end
      ST_IDLE: begin
        mem_req.grid_raddr = cell_addr(row_m1[ROW_W-1:0], col_m1[ROW_W-1:0]);
      end
      ST_FILL: begin
        mem_req.grid_we    = 1'b1;
        mem_req.grid_waddr = cell_addr(i, j);
        mem_req.grid_wdata = fill_val;
      end
      ST_ROT1, ST_GAP: begin
        mem_req.scr_we = pend_valid;
      end
      ST_ROT2, ST_FLUSH: begin
        mem_req.grid_we    = pend_valid;
        mem_req.grid_waddr = pend_addr;
        mem_req.grid_wdata = scr_q;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: clearing pass, fill walk, two rotate passes, cell read.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= 1'b0;
      pend_valid <= (state == ST_ROT1) || (state == ST_ROT2);
      if (state == ST_ROT1) begin
        pend_addr <= dst_addr;
      end else begin
        pend_addr <= src_addr;
      end
      if ((state == ST_FILL) || (state == ST_ROT1) || (state == ST_ROT2)) begin
        if (last_row) begin
          j <= '0;
          i <= i + ROW_W'(1);
        end else begin
          j <= j + ROW_W'(1);
        end
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            i          <= '0;
            j          <= '0;
            cell_value <= '0;
            status     <= STATUS_IGNORED;
            unique case (opcode)
              OP_FILL: begin
                status   <= STATUS_DONE;
                lim      <= side_m1[ROW_W-1:0];
                fill_val <= CELL_W'(1);
                if (side == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= ST_FILL;
                end
              end
              OP_ROTATE: begin
                lim <= ROW_W'({radius, 1'b0});
                tr  <= top_row[ROW_W-1:0];
                tc  <= top_col[ROW_W-1:0];
                dir <= direction;
                if (rot_ok) begin
                  state <= ST_ROT1;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_READ: begin
                if (rd_ok) begin
                  state <= ST_READ;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_FILL: begin
          fill_val <= fill_val + CELL_W'(1);
          if (last_cell) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_ROT1: begin
          if (last_cell) begin
            state <= ST_GAP;
          end
        end
        ST_GAP: begin
          i     <= '0;
          j     <= '0;
          state <= ST_ROT2;
        end
        ST_ROT2: begin
          if (last_cell) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          status <= STATUS_DONE;
          done   <= 1'b1;
          state  <= ST_IDLE;
        end
        ST_READ: begin
          cell_value <= grid_q;
          status     <= STATUS_DONE;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/square_tile_rotator.sv -----
// Square tile rotator: keeps a 64 by 64 grid of 13-bit cells in a memory.
// Items enter on start while busy is low and carry opcode, center_row,
// center_col, radius and direction. Each item gives one result, shown for
// one cycle with done high on cell_value and status; the receiver cannot
// hold results off.
// The side in use is written over cfg_valid/cfg_data (cfg_ready is always
// high); the user must write it only while the block is idle, since the
// block itself does not enforce this.
// Work per item (n = 2*radius+1):
//   read: one grid read; error or unused opcode: no pass, next item at
//   once; fill: one cell write per cycle over the side by side area;
//   rotate: the first pass copies each cell of the n by n square from the
//   grid memory to its turned place in the scratch memory, one per cycle;
//   the second copies it back. A gap state between passes lets the last
//   scratch write land, and a flush state lets the last grid write land.
// The next item is taken in the cycle done is high. After reset a clearing
// pass writes zero to all 4096 grid cells, one per cycle; busy stays high.
module square_tile_rotator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [sqtr_pkg::OP_W-1:0]    opcode,
  input  logic [sqtr_pkg::SIDE_W-1:0]  center_row,
  input  logic [sqtr_pkg::SIDE_W-1:0]  center_col,
  input  logic [sqtr_pkg::RAD_W-1:0]   radius,
  input  logic                         direction,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sqtr_pkg::SIDE_W-1:0]  cfg_data,
  output logic                         done,
  output logic [sqtr_pkg::CELL_W-1:0]  cell_value,
  output logic                         status
);
  import sqtr_pkg::*;

  logic [SIDE_W-1:0] grid_side;
  logic [CMP_W-1:0]  side_use;
  logic [CELL_W-1:0] grid_q;
  logic [CELL_W-1:0] scr_q;
  mem_req_t          mem_req;

  // Side register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= GRID_SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      grid_side <= cfg_data;
    end
  end

  // A side above the store width acts as the full store width.
  assign side_use = (CMP_W'(grid_side) > CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE)
                                                          : CMP_W'(grid_side);

  sqtr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .center_row (center_row),
    .center_col (center_col),
    .radius     (radius),
    .direction  (direction),
    .side       (side_use),
    .grid_q     (grid_q),
    .scr_q      (scr_q),
    .mem_req    (mem_req),
    .done       (done),
    .cell_value (cell_value),
    .status     (status)
  );

  // Grid memory.
  sqtr_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk   (clk),
    .we    (mem_req.grid_we),
    .waddr (mem_req.grid_waddr),
    .wdata (mem_req.grid_wdata),
    .raddr (mem_req.grid_raddr),
    .rdata (grid_q)
  );

  // Scratch memory for the turned square.
  sqtr_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_scr_ram (
    .clk   (clk),
    .we    (mem_req.scr_we),
    .waddr (mem_req.scr_waddr),
    .wdata (mem_req.scr_wdata),
    .raddr (mem_req.scr_raddr),
    .rdata (scr_q)
  );

endmodule
